// File: hw/rtl/hash_bucket_key_value_slots_assert.svh
// Assertion macros used by the bucket RTL.
`ifndef HASH_BUCKET_KEY_VALUE_SLOTS_ASSERT_SVH
`define HASH_BUCKET_KEY_VALUE_SLOTS_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define HBKV_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bucket assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define HBKV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bucket assertion failed");

`endif

// File: hw/rtl/hbkv_pkg.sv
`default_nettype none

package hbkv_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 64;

    localparam logic [2:0] ACT_LOOKUP   = 3'd0;
    localparam logic [2:0] ACT_INSERT   = 3'd1;
    localparam logic [2:0] ACT_REM_KEY  = 3'd2;
    localparam logic [2:0] ACT_REM_SLOT = 3'd3;
    localparam logic [2:0] ACT_READ     = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] key;
        logic [63:0] write_value;
        logic [5:0]  slot;
    } req_t;

    typedef struct packed {
        logic        success;
        logic [63:0] read_value;
        logic [63:0] read_key;
        logic [5:0]  slot_used;
        logic        slot_occupied;
        logic [6:0]  occupied_count;
        logic        bucket_full;
        logic        modified;
    } rsp_t;

    typedef struct packed {
        logic set;
        logic clr;
    } occ_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/hash_bucket_key_value_slots.sv
// Bucket of key/value slots with lookup, insert, remove by key, remove at
// slot and read slot requests.
// A request is taken at a clock edge where start is high and busy is low;
// req carries the action, key, value and slot index.
// Each request gives one result on rsp, marked by done for exactly one
// cycle; the receiver cannot hold it off, and the next request may be
// started in the same cycle as done.
// Lookup, insert and remove by key scan the single-port slot memory one
// entry a cycle, stopping at the lowest match. The memory read is
// registered and the key compare follows it; a hit, or the compare of the
// last entry with no hit, ends the scan in a commit state that raises done.
// Read slot of an in-range slot passes through a read-wait state; remove
// at slot, an out-of-range read slot and undefined actions answer from idle.
// Reset clears every occupied bit and the count; slot keys and values are
// undefined until written, so a read of a never-written slot returns
// arbitrary key and value.
`default_nettype none

module hash_bucket_key_value_slots #(
    parameter int SLOTS      = hbkv_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = hbkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = hbkv_pkg::VALUE_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire hbkv_pkg::req_t req,
    output logic                done,
    output hbkv_pkg::rsp_t      rsp
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int DATA_W = KEY_BITS + VALUE_BITS;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_RDWAIT
    } state_t;

    state_t                state_reg;
    logic [2:0]            act_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] wval_reg;
    logic [5:0]            slot_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic                  cmp_vld_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [VALUE_BITS-1:0] hit_val_reg;
    logic                  free_vld_reg;
    logic [IDX_W-1:0]      free_idx_reg;

    logic                  done_reg;
    logic                  success_reg;
    logic [63:0]           rval_reg;
    logic [63:0]           rkey_reg;
    logic [5:0]            used_reg;
    logic                  socc_reg;
    logic                  mod_reg;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_addr;
    logic [DATA_W-1:0]     ram_wdata;
    logic [DATA_W-1:0]     ram_rdata;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;

    logic [IDX_W-1:0]      occ_idx;
    hbkv_pkg::occ_cmd_t    occ_cmd;
    logic                  occ_bit;
    logic [CNT_W-1:0]      occ_count;

    logic                  accept;
    logic [IDX_W-1:0]      req_idx;
    logic                  req_in_range;
    logic [IDX_W-1:0]      tgt_idx;
    logic                  scan_hit;
    logic [6:0]            cnt_sat;

    assign accept       = start && (state_reg == ST_IDLE);
    assign busy         = (state_reg != ST_IDLE);
    assign req_idx      = IDX_W'(req.slot);
    assign req_in_range = (32'(req.slot) < SLOTS);
    assign tgt_idx      = found_reg ? hit_idx_reg : free_idx_reg;
    assign rd_key       = ram_rdata[DATA_W-1 -: KEY_BITS];
    assign rd_val       = ram_rdata[VALUE_BITS-1:0];
    assign scan_hit     = cmp_vld_reg && occ_bit && (rd_key == key_reg);
    assign ram_wdata    = {key_reg, wval_reg};

    always_comb
    begin
        ram_we  = 1'b0;
        occ_cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_addr    = req_idx;
                occ_idx     = req_idx;
                occ_cmd.clr = accept && (req.action == hbkv_pkg::ACT_REM_SLOT)
                              && req_in_range;
            end
            ST_SCAN:
            begin
                ram_addr = rd_idx_reg;
                occ_idx  = cmp_idx_reg;
            end
            ST_COMMIT:
            begin
                ram_addr    = tgt_idx;
                occ_idx     = tgt_idx;
                ram_we      = (act_reg == hbkv_pkg::ACT_INSERT)
                              && (found_reg || free_vld_reg);
                occ_cmd.set = (act_reg == hbkv_pkg::ACT_INSERT) && !found_reg
                              && free_vld_reg;
                occ_cmd.clr = (act_reg == hbkv_pkg::ACT_REM_KEY) && found_reg;
            end
            ST_RDWAIT:
            begin
                ram_addr = IDX_W'(slot_reg);
                occ_idx  = IDX_W'(slot_reg);
            end
        endcase
    end

    hbkv_slot_ram #(
        .DEPTH  (SLOTS),
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    hbkv_occ #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_occ (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (occ_idx),
        .cmd   (occ_cmd),
        .occ   (occ_bit),
        .count (occ_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            act_reg      <= '0;
            key_reg      <= '0;
            wval_reg     <= '0;
            slot_reg     <= '0;
            rd_idx_reg   <= '0;
            cmp_idx_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
            hit_idx_reg  <= '0;
            hit_val_reg  <= '0;
            free_vld_reg <= 1'b0;
            free_idx_reg <= '0;
            done_reg     <= 1'b0;
            success_reg  <= 1'b0;
            rval_reg     <= '0;
            rkey_reg     <= '0;
            used_reg     <= '0;
            socc_reg     <= 1'b0;
            mod_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        act_reg      <= req.action;
                        key_reg      <= req.key[KEY_BITS-1:0];
                        wval_reg     <= req.write_value[VALUE_BITS-1:0];
                        slot_reg     <= req.slot;
                        rd_idx_reg   <= '0;
                        cmp_vld_reg  <= 1'b0;
                        free_vld_reg <= 1'b0;
                        success_reg  <= 1'b0;
                        rval_reg     <= '0;
                        rkey_reg     <= '0;
                        used_reg     <= '0;
                        socc_reg     <= 1'b0;
                        mod_reg      <= 1'b0;
                        unique case (req.action)
                            hbkv_pkg::ACT_LOOKUP,
                            hbkv_pkg::ACT_INSERT,
                            hbkv_pkg::ACT_REM_KEY:
                            begin
                                state_reg <= ST_SCAN;
                            end
                            hbkv_pkg::ACT_REM_SLOT:
                            begin
                                done_reg    <= 1'b1;
                                used_reg    <= req.slot;
                                success_reg <= req_in_range;
                                mod_reg     <= req_in_range;
                            end
                            hbkv_pkg::ACT_READ:
                            begin
                                used_reg <= req.slot;
                                if (req_in_range)
                                begin
                                    state_reg <= ST_RDWAIT;
                                end
                                else
                                begin
                                    done_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (rd_idx_reg != LAST)
                    begin
                        rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                    end
                    cmp_idx_reg <= rd_idx_reg;
                    cmp_vld_reg <= 1'b1;
                    if (scan_hit)
                    begin
                        found_reg   <= 1'b1;
                        hit_idx_reg <= cmp_idx_reg;
                        hit_val_reg <= rd_val;
                        state_reg   <= ST_COMMIT;
                    end
                    else if (cmp_vld_reg)
                    begin
                        if (!occ_bit && !free_vld_reg)
                        begin
                            free_vld_reg <= 1'b1;
                            free_idx_reg <= cmp_idx_reg;
                        end
                        if (cmp_idx_reg == LAST)
                        begin
                            found_reg <= 1'b0;
                            state_reg <= ST_COMMIT;
                        end
                    end
                end
                ST_COMMIT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                    if (found_reg)
                    begin
                        success_reg <= 1'b1;
                        used_reg    <= 6'(hit_idx_reg);
                        mod_reg     <= (act_reg != hbkv_pkg::ACT_LOOKUP);
                        if (act_reg == hbkv_pkg::ACT_LOOKUP)
                        begin
                            rval_reg <= 64'(hit_val_reg);
                        end
                    end
                    else if ((act_reg == hbkv_pkg::ACT_INSERT) && free_vld_reg)
                    begin
                        success_reg <= 1'b1;
                        used_reg    <= 6'(free_idx_reg);
                        mod_reg     <= 1'b1;
                    end
                end
                ST_RDWAIT:
                begin
                    done_reg    <= 1'b1;
                    state_reg   <= ST_IDLE;
                    success_reg <= 1'b1;
                    rkey_reg    <= 64'(rd_key);
                    rval_reg    <= 64'(rd_val);
                    socc_reg    <= occ_bit;
                end
            endcase
        end
    end

    // The count is read live: during done it already holds the value after
    // the transaction that is being reported.
    always_comb
    begin
        if (32'(occ_count) > 127)
        begin
            cnt_sat = 7'd127;
        end
        else
        begin
            cnt_sat = 7'(occ_count);
        end
    end

    assign done = done_reg;

    always_comb
    begin
        rsp.success        = success_reg;
        rsp.read_value     = rval_reg;
        rsp.read_key       = rkey_reg;
        rsp.slot_used      = used_reg;
        rsp.slot_occupied  = socc_reg;
        rsp.occupied_count = cnt_sat;
        rsp.bucket_full    = (32'(occ_count) == SLOTS);
        rsp.modified       = mod_reg;
    end

`include "hash_bucket_key_value_slots_assert.svh"

    `HBKV_ASSERT_IMPL(a_done_idle, done, !busy)
    `HBKV_ASSERT_IMPL(a_mod_success, done && rsp.modified, rsp.success)
    `HBKV_ASSERT_NEXT(a_scan_busy, accept && (req.action == hbkv_pkg::ACT_LOOKUP), busy)
    `HBKV_ASSERT_IMPL(a_count_bound, 1'b1, 32'(occ_count) <= SLOTS)

endmodule

`default_nettype wire

// File: hw/rtl/hbkv_slot_ram.sv
`default_nettype none

module hbkv_slot_ram #(
    parameter int DEPTH  = hbkv_pkg::SLOTS_DEF,
    parameter int ADDR_W = $clog2(hbkv_pkg::SLOTS_DEF),
    parameter int DATA_W = hbkv_pkg::KEY_BITS_DEF + hbkv_pkg::VALUE_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hbkv_occ.sv
`default_nettype none

module hbkv_occ #(
    parameter int SLOTS = hbkv_pkg::SLOTS_DEF,
    parameter int IDX_W = $clog2(hbkv_pkg::SLOTS_DEF),
    parameter int CNT_W = $clog2(hbkv_pkg::SLOTS_DEF + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [IDX_W-1:0]   idx,
    input  wire hbkv_pkg::occ_cmd_t cmd,
    output logic                    occ,
    output logic      [CNT_W-1:0]   count
);

    logic [SLOTS-1:0] occ_reg;
    logic [CNT_W-1:0] count_reg;

    assign occ   = occ_reg[idx];
    assign count = count_reg;

    // The count only moves when the addressed bit really changes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.set && !occ_reg[idx])
        begin
            occ_reg[idx] <= 1'b1;
            count_reg    <= count_reg + CNT_W'(1);
        end
        else if (cmd.clr && occ_reg[idx])
        begin
            occ_reg[idx] <= 1'b0;
            count_reg    <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire
